@@ design/kc3_pkg.sv @@
// ----------------------------------------------------------------------------
// kc3_pkg
// Shared types and constants of the 3x3 convolution core: register indexes,
// the record that travels down the multiply-accumulate chain, and the fixed
// constants of the divide-by-nine stage.
// ----------------------------------------------------------------------------
`default_nettype none

package kc3_pkg;

	localparam int PIX_W   = 8;
	localparam int NTAPS   = 9;
	localparam int KROW_W  = 24;
	localparam int COEF_W  = 8;
	localparam int PSUM_W  = 20;
	localparam int MAG_W   = 19;
	localparam int QUO_W   = 16;

	// Unsigned divide by nine: q = (n * DIV_RECIP) >> DIV_SHIFT, exact for n < 2**MAG_W.
	localparam int RECIP_W   = 20;
	localparam int DIV_SHIFT = 23;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 20'd932068;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MID    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

	typedef logic [NTAPS-1:0][PIX_W-1:0] pixvec_t;

	typedef struct packed {
		logic                     valid;
		logic                     conv;
		logic                     last;
		logic [PIX_W-1:0]         pass;
		pixvec_t                  pix;
		logic signed [PSUM_W-1:0] psum;
	} chain_t;

	typedef struct packed {
		logic             last;
		logic [PIX_W-1:0] value;
	} res_t;

endpackage

`default_nettype wire

@@ design/kernel_convolution_3x3_core.sv @@
// ----------------------------------------------------------------------------
// kernel_convolution_3x3_core
// Streaming 3x3 convolution of 8-bit grayscale pixels with a signed kernel,
// scaled by one ninth; border pixels pass through and flush items drain the
// results still held at the end of a frame.
// ----------------------------------------------------------------------------
// Pipeline: line store read, nine chained MAC cells, two divide stages, then the
//   output register. Throughput: one item per cycle while the skid register is
//   empty; a pixel produces the result one row plus one column behind it, so a
//   frame needs image_width + 1 flush items to drain.
// Reset: counters, window, output stages and registers (640 x 480, zero kernel)
//   are cleared at once; the two line stores are not cleared and need no pass.
`default_nettype none

module kernel_convolution_3x3_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata,   // [7:0] pixel_value
	input  wire logic                                s_tuser,   // [0] req_type
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [7:0]                               m_tdata,   // [7:0] result_value
	output logic                                     m_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [kc3_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [kc3_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WMAX = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
	localparam int WB   = $clog2(WMAX + 1);
	localparam int QW   = $clog2(WMAX * 65535 + 1);
	localparam int PW   = kc3_pkg::PIX_W;

	localparam logic [1:0] SRC_CORNER = 2'd0;
	localparam logic [1:0] SRC_CENTER = 2'd1;
	localparam logic [1:0] SRC_LOWER  = 2'd2;
	localparam logic [1:0] SRC_CONV   = 2'd3;

	// Configuration registers.
	logic [10:0]               cfg_width_q;
	logic [15:0]               cfg_height_q;
	logic [kc3_pkg::KROW_W-1:0] k_top_q;
	logic [kc3_pkg::KROW_W-1:0] k_mid_q;
	logic [kc3_pkg::KROW_W-1:0] k_bot_q;

	// Input position and drain position.
	logic [WB-1:0]  col_q;
	logic [15:0]    row_q;
	logic [QW-1:0]  opos_q;

	logic [WB-1:0]  w_used;
	logic [WB-1:0]  w_m1;
	logic [15:0]    h_used;
	logic [WB-1:0]  x;
	logic [15:0]    y;
	logic [QW-1:0]  q;
	logic [QW-1:0]  frame;
	logic [QW-1:0]  base;
	logic [QW-1:0]  fl_off;
	logic           pix_emit;
	logic [1:0]     pix_src;
	logic           fl_ok;
	logic           fl_lower;
	logic           fl_last;
	logic [QW-1:0]  fl_next;

	logic           en;
	logic           acc;
	logic           acc_pix;
	logic           acc_fl;

	// Line stores: the upper store is kept twice so that it offers two reads.
	logic [PW-1:0]  lo_rd;
	logic [PW-1:0]  upa_rd;
	logic [PW-1:0]  upb_rd;
	logic [AW-1:0]  lo_raddr;
	logic           pw_valid_q;
	logic [AW-1:0]  pw_addr_q;
	logic           bypa_q;
	logic           bypb_q;
	logic [PW-1:0]  byp_data_q;

	// Stage 1: line store data is ready.
	logic           s1_upd_s1;
	logic           s1_out_s1;
	logic [1:0]     s1_src_s1;
	logic           s1_last_s1;
	logic [PW-1:0]  s1_pix_s1;
	logic [PW-1:0]  up_px;
	logic [PW-1:0]  corner_px;
	logic [PW-1:0]  pass_px;

	kc3_pkg::pixvec_t win_q;
	kc3_pkg::pixvec_t win_nxt;

	logic [2:0][kc3_pkg::KROW_W-1:0]     krows;
	logic signed [kc3_pkg::COEF_W-1:0]   coef [kc3_pkg::NTAPS];
	kc3_pkg::chain_t                     chain [kc3_pkg::NTAPS+1];

	logic           div_valid;
	kc3_pkg::res_t  div_res;
	logic           out_valid_q;
	kc3_pkg::res_t  out_q;
	logic           skid_valid_q;
	kc3_pkg::res_t  skid_q;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= 11'd640;
			cfg_height_q <= 16'd480;
			k_top_q      <= '0;
			k_mid_q      <= '0;
			k_bot_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kc3_pkg::REG_IMAGE_WIDTH:   cfg_width_q  <= cfg_data[10:0];
				kc3_pkg::REG_IMAGE_HEIGHT:  cfg_height_q <= cfg_data[15:0];
				kc3_pkg::REG_KERNEL_TOP:    k_top_q      <= cfg_data;
				kc3_pkg::REG_KERNEL_MID:    k_mid_q      <= cfg_data;
				kc3_pkg::REG_KERNEL_BOTTOM: k_bot_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cfg_width_q < 11'd3) begin
			w_used = WB'(3);
		end else if (cfg_width_q > 11'(WMAX)) begin
			w_used = WB'(WMAX);
		end else begin
			w_used = WB'(cfg_width_q);
		end
	end

	assign h_used = (cfg_height_q < 16'd3) ? 16'd3 : cfg_height_q;
	assign w_m1   = w_used - WB'(1);

	// ------------------------------------------------------------- stage 0
	assign en      = !skid_valid_q;
	assign s_tready = en;
	assign acc     = s_tvalid && s_tready;
	assign acc_pix = acc && !s_tuser;
	assign acc_fl  = acc && s_tuser;

	assign x     = (col_q >= w_used) ? w_m1 : col_q;
	assign y     = (row_q >= h_used) ? (h_used - 16'd1) : row_q;
	assign q     = QW'(y) * QW'(w_used) + QW'(x);
	assign frame = QW'(h_used) * QW'(w_used);
	assign base  = frame - QW'(w_used);

	// A pixel produces a result once a full row and one more pixel are in.
	assign pix_emit = !((y == 16'd0) || ((y == 16'd1) && (x == '0)));

	always_comb begin
		if (x == '0) begin
			pix_src = SRC_CORNER;
		end else if ((y == 16'd1) || (x == WB'(1))) begin
			pix_src = SRC_CENTER;
		end else begin
			pix_src = SRC_CONV;
		end
	end

	assign fl_ok    = (col_q == '0) && (row_q == 16'd0) && (opos_q != '0) && (opos_q < frame);
	assign fl_off   = opos_q - base;
	assign fl_lower = (opos_q >= base) && (fl_off < QW'(w_used));
	assign fl_last  = (opos_q == frame - QW'(1));
	assign fl_next  = ((opos_q + QW'(1)) >= frame) ? '0 : (opos_q + QW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			opos_q <= '0;
		end else if (acc_pix) begin
			if ((x + WB'(1)) >= w_used) begin
				col_q <= '0;
				row_q <= ((y + 16'd1) >= h_used) ? 16'd0 : (y + 16'd1);
			end else begin
				col_q <= x + WB'(1);
				row_q <= y;
			end
			opos_q <= pix_emit ? (q - QW'(w_used)) : '0;
		end else if (acc_fl && fl_ok) begin
			opos_q <= fl_next;
		end
	end

	assign lo_raddr = s_tuser ? AW'(fl_off) : AW'(x);

	kc3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (acc_pix),
		.waddr (AW'(x)),
		.wdata (s_tdata),
		.re    (acc),
		.raddr (lo_raddr),
		.rdata (lo_rd)
	);

	// The upper store takes the old lower entry in the cycle after the transfer,
	// once that entry has been read out.
	kc3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper_a (
		.clk   (clk),
		.we    (pw_valid_q),
		.waddr (pw_addr_q),
		.wdata (lo_rd),
		.re    (acc),
		.raddr (AW'(x)),
		.rdata (upa_rd)
	);

	kc3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper_b (
		.clk   (clk),
		.we    (pw_valid_q),
		.waddr (pw_addr_q),
		.wdata (lo_rd),
		.re    (acc),
		.raddr (AW'(w_m1)),
		.rdata (upb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_valid_q <= 1'b0;
		end else begin
			pw_valid_q <= acc_pix;
		end
	end

	// A read that meets the delayed write in the same cycle takes the written data.
	always_ff @(posedge clk) begin
		if (acc_pix) begin
			pw_addr_q <= AW'(x);
		end
		if (acc) begin
			bypa_q     <= pw_valid_q && (AW'(x) == pw_addr_q);
			bypb_q     <= pw_valid_q && (AW'(w_m1) == pw_addr_q);
			byp_data_q <= lo_rd;
		end
	end

	// ------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_upd_s1 <= 1'b0;
			s1_out_s1 <= 1'b0;
		end else if (en) begin
			s1_upd_s1 <= acc_pix;
			s1_out_s1 <= acc_pix ? pix_emit : (acc_fl && fl_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_src_s1  <= s_tuser ? (fl_lower ? SRC_LOWER : SRC_CORNER) : pix_src;
			s1_last_s1 <= s_tuser && fl_last;
			s1_pix_s1  <= s_tdata;
		end
	end

	assign up_px     = bypa_q ? byp_data_q : upa_rd;
	assign corner_px = bypb_q ? byp_data_q : upb_rd;

	always_comb begin
		win_nxt[0] = win_q[1];
		win_nxt[1] = win_q[2];
		win_nxt[2] = up_px;
		win_nxt[3] = win_q[4];
		win_nxt[4] = win_q[5];
		win_nxt[5] = lo_rd;
		win_nxt[6] = win_q[7];
		win_nxt[7] = win_q[8];
		win_nxt[8] = s1_pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (en && s1_upd_s1) begin
			win_q <= win_nxt;
		end
	end

	always_comb begin
		case (s1_src_s1)
			SRC_CORNER: pass_px = corner_px;
			SRC_CENTER: pass_px = win_nxt[4];
			SRC_LOWER:  pass_px = lo_rd;
			default:    pass_px = '0;
		endcase
	end

	always_comb begin
		chain[0].valid = s1_out_s1;
		chain[0].conv  = (s1_src_s1 == SRC_CONV);
		chain[0].last  = s1_last_s1;
		chain[0].pass  = pass_px;
		chain[0].pix   = win_nxt;
		chain[0].psum  = '0;
	end

	// ---------------------------------------------------------- MAC chain
	// Tap k of the window is weighted by the kernel entry rotated half a turn.
	assign krows = {k_bot_q, k_mid_q, k_top_q};

	for (genvar k = 0; k < kc3_pkg::NTAPS; k++) begin : g_tap
		assign coef[k] = $signed(krows[2 - k / 3][kc3_pkg::COEF_W * (2 - k % 3) +: kc3_pkg::COEF_W]);

		kc3_mac_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.coef   (coef[k]),
			.din    (chain[k]),
			.dout   (chain[k+1])
		);
	end

	kc3_div9 u_div9 (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.din        (chain[kc3_pkg::NTAPS]),
		.dout_valid (div_valid),
		.dout       (div_res)
	);

	// -------------------------------------------------------- output skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && !m_tready) begin
			if (div_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (out_valid_q && !m_tready) begin
			if (div_valid) begin
				skid_q <= div_res;
			end
		end else begin
			out_q <= div_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.value;
	assign m_tlast  = out_q.last;

	// ---------------------------------------------------------- assertions
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_delayed_write: assert property (@(posedge clk) disable iff (!arst_n)
		pw_valid_q |-> $past(acc_pix))
		else $error("upper line store written without a pixel transfer one cycle before");

	a_conv_from_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_out_s1 && (s1_src_s1 == SRC_CONV)) |-> s1_upd_s1)
		else $error("filtered result issued without a window update");

endmodule

`default_nettype wire

@@ design/kc3_ram.sv @@
// ----------------------------------------------------------------------------
// kc3_ram
// Generic single-write, single-read memory with a registered read port.
// A read and a write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module kc3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                   wdata,
	input  wire logic                               re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/kc3_mac_cell.sv @@
// ----------------------------------------------------------------------------
// kc3_mac_cell
// One tap of the convolution chain: multiplies the front pixel of the window
// by its coefficient, adds it to the running sum and hands the record on with
// the window moved one tap forward.
// ----------------------------------------------------------------------------
`default_nettype none

module kc3_mac_cell (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic signed [kc3_pkg::COEF_W-1:0]   coef,
	input  wire kc3_pkg::chain_t                     din,
	output kc3_pkg::chain_t                          dout
);

	logic signed [kc3_pkg::COEF_W+kc3_pkg::PIX_W:0] prod;
	kc3_pkg::pixvec_t                               pix_nxt;
	kc3_pkg::chain_t                                rec_q;
	logic                                           valid_q;

	assign prod = coef * $signed({1'b0, din.pix[0]});

	always_comb begin
		for (int i = 0; i < kc3_pkg::NTAPS - 1; i++) begin
			pix_nxt[i] = din.pix[i+1];
		end
		pix_nxt[kc3_pkg::NTAPS-1] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_q.valid <= din.valid;
			rec_q.conv  <= din.conv;
			rec_q.last  <= din.last;
			rec_q.pass  <= din.pass;
			rec_q.pix   <= pix_nxt;
			rec_q.psum  <= din.psum + kc3_pkg::PSUM_W'(prod);
		end
	end

	always_comb begin
		dout       = rec_q;
		dout.valid = valid_q;
	end

endmodule

`default_nettype wire

@@ design/kc3_div9.sv @@
// ----------------------------------------------------------------------------
// kc3_div9
// Two-stage signed divide by nine, truncating toward zero, followed by the
// choice between the filtered value and the passed-through pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module kc3_div9 (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire kc3_pkg::chain_t  din,
	output logic                  dout_valid,
	output kc3_pkg::res_t         dout
);

	localparam int PROD_W = kc3_pkg::MAG_W + kc3_pkg::RECIP_W;

	logic                          a_valid_q;
	logic                          a_conv_q;
	logic                          a_last_q;
	logic [kc3_pkg::PIX_W-1:0]     a_pass_q;
	logic                          a_neg_q;
	logic [kc3_pkg::MAG_W-1:0]     a_mag_q;
	logic                          b_valid_q;
	logic                          b_conv_q;
	logic                          b_last_q;
	logic [kc3_pkg::PIX_W-1:0]     b_pass_q;
	logic                          b_neg_q;
	logic [kc3_pkg::QUO_W-1:0]     b_quo_q;
	logic signed [kc3_pkg::PSUM_W-1:0] mag_full;
	logic [PROD_W-1:0]             prod;
	logic [kc3_pkg::PIX_W-1:0]     quo_lo;

	assign mag_full = din.psum[kc3_pkg::PSUM_W-1] ? -din.psum : din.psum;
	assign prod     = PROD_W'(a_mag_q) * PROD_W'(kc3_pkg::DIV_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else if (en) begin
			a_valid_q <= din.valid;
			b_valid_q <= a_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_conv_q <= din.conv;
			a_last_q <= din.last;
			a_pass_q <= din.pass;
			a_neg_q  <= din.psum[kc3_pkg::PSUM_W-1];
			a_mag_q  <= kc3_pkg::MAG_W'(mag_full);
			b_conv_q <= a_conv_q;
			b_last_q <= a_last_q;
			b_pass_q <= a_pass_q;
			b_neg_q  <= a_neg_q;
			b_quo_q  <= prod[kc3_pkg::DIV_SHIFT +: kc3_pkg::QUO_W];
		end
	end

	// Only the low byte of the quotient survives, so the negation is done on it alone.
	assign quo_lo = b_quo_q[kc3_pkg::PIX_W-1:0];

	always_comb begin
		dout_valid = b_valid_q;
		dout.last  = b_last_q;
		if (b_conv_q) begin
			dout.value = b_neg_q ? (kc3_pkg::PIX_W'(0) - quo_lo) : quo_lo;
		end else begin
			dout.value = b_pass_q;
		end
	end

endmodule

`default_nettype wire
